// ===== rtl/core/hpm_pkg.sv =====
package hpm_pkg;

    localparam int COEF_BITS = 32;
    localparam int NUM_COEF  = 8;
    localparam int OUT_BITS  = 16;
    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 32;

    localparam logic signed [COEF_BITS-1:0] ONE_Q16 = 32'sd65536;

    typedef logic signed [COEF_BITS-1:0] t_coef;

    typedef enum logic [2:0] {
        REG_H00 = 3'd0,
        REG_H01 = 3'd1,
        REG_H02 = 3'd2,
        REG_H10 = 3'd3,
        REG_H11 = 3'd4,
        REG_H12 = 3'd5,
        REG_H20 = 3'd6,
        REG_H21 = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_ZERO = 2'd2
    } t_status;

    // Per-point control that travels alongside the division operands.
    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic zero;
    } t_div_flags;

    localparam int FLAG_BITS = $bits(t_div_flags);

endpackage

// ===== rtl/core/hpm_queue.sv =====
module hpm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

endmodule

// ===== rtl/core/hpm_front.sv =====
module hpm_front #(
    parameter int COORD_BITS = 11,
    parameter int FRAC_BITS  = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [COORD_BITS-1:0]      i_x,
    input  logic [COORD_BITS-1:0]      i_y,
    input  hpm_pkg::t_coef             i_coef [hpm_pkg::NUM_COEF],
    output logic                       o_valid,
    output logic [COORD_BITS+FRAC_BITS+36:0] o_nx_mag,
    output logic [COORD_BITS+FRAC_BITS+36:0] o_ny_mag,
    output logic [COORD_BITS+35:0]     o_d_mag,
    output hpm_pkg::t_div_flags        o_flags
);
    import hpm_pkg::*;

    localparam int PW = COEF_BITS + COORD_BITS + 1;
    localparam int SW = PW + 2;
    localparam int NW = SW + FRAC_BITS + 2;
    localparam int DW = SW + 1;

    logic signed [COORD_BITS:0] xs;
    logic signed [COORD_BITS:0] ys;

    logic signed [PW-1:0] r_p_xx, r_p_xy, r_p_yx, r_p_yy, r_p_dx, r_p_dy;
    logic signed [SW-1:0] r_nx, r_ny, r_d;
    logic [2:0]           r_v;

    logic [SW-1:0] nx_mag, ny_mag, d_mag;
    logic [NW-1:0] r_nx_n, r_ny_n;
    logic [DW-1:0] r_d_n;
    t_div_flags    r_flags;

    assign xs = $signed({1'b0, i_x});
    assign ys = $signed({1'b0, i_y});

    // Stage 1: the six coordinate products.
    always_ff @(posedge i_clk) begin
        r_p_xx <= i_coef[REG_H00] * xs;
        r_p_xy <= i_coef[REG_H01] * ys;
        r_p_yx <= i_coef[REG_H10] * xs;
        r_p_yy <= i_coef[REG_H11] * ys;
        r_p_dx <= i_coef[REG_H20] * xs;
        r_p_dy <= i_coef[REG_H21] * ys;
    end

    // Stage 2: homogeneous sums.
    always_ff @(posedge i_clk) begin
        r_nx <= SW'(r_p_xx) + SW'(r_p_xy) + SW'(i_coef[REG_H02]);
        r_ny <= SW'(r_p_yx) + SW'(r_p_yy) + SW'(i_coef[REG_H12]);
        r_d  <= SW'(r_p_dx) + SW'(r_p_dy) + SW'(ONE_Q16);
    end

    assign nx_mag = r_nx[SW-1] ? SW'(-r_nx) : SW'(r_nx);
    assign ny_mag = r_ny[SW-1] ? SW'(-r_ny) : SW'(r_ny);
    assign d_mag  = r_d[SW-1]  ? SW'(-r_d)  : SW'(r_d);

    // Stage 3: rounding operands. Rounding to nearest is floor((2n + d) / 2d).
    always_ff @(posedge i_clk) begin
        r_nx_n        <= (NW'(nx_mag) << (FRAC_BITS + 1)) + NW'(d_mag);
        r_ny_n        <= (NW'(ny_mag) << (FRAC_BITS + 1)) + NW'(d_mag);
        r_d_n         <= DW'(d_mag) << 1;
        r_flags.neg_x <= r_nx[SW-1] ^ r_d[SW-1];
        r_flags.neg_y <= r_ny[SW-1] ^ r_d[SW-1];
        r_flags.zero  <= (r_d == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    assign o_valid  = r_v[2];
    assign o_nx_mag = r_nx_n;
    assign o_ny_mag = r_ny_n;
    assign o_d_mag  = r_d_n;
    assign o_flags  = r_flags;

endmodule

// ===== rtl/core/hpm_back.sv =====
module hpm_back #(
    parameter int COORD_BITS = 11,
    parameter int FRAC_BITS  = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [COORD_BITS+FRAC_BITS+36:0] i_nx_mag,
    input  logic [COORD_BITS+FRAC_BITS+36:0] i_ny_mag,
    input  logic [COORD_BITS+35:0]           i_d_mag,
    input  hpm_pkg::t_div_flags              i_flags,
    output logic                             o_valid,
    output logic [hpm_pkg::OUT_BITS-1:0]     o_x,
    output logic [hpm_pkg::OUT_BITS-1:0]     o_y,
    output hpm_pkg::t_status                 o_status
);
    import hpm_pkg::*;

    localparam int SW = COEF_BITS + COORD_BITS + 3;
    localparam int NW = SW + FRAC_BITS + 2;
    localparam int DW = SW + 1;
    localparam int WW = NW + OUT_BITS;

    logic [WW-1:0]       r_rem_x [OUT_BITS+1];
    logic [WW-1:0]       r_rem_y [OUT_BITS+1];
    logic [DW-1:0]       r_d     [OUT_BITS+1];
    logic [OUT_BITS-1:0] r_q_x   [OUT_BITS+1];
    logic [OUT_BITS-1:0] r_q_y   [OUT_BITS+1];
    logic [OUT_BITS:0]   r_ovf_x;
    logic [OUT_BITS:0]   r_ovf_y;
    t_div_flags          r_fl    [OUT_BITS+1];
    logic [OUT_BITS:0]   r_v;

    logic [WW-1:0]       d_top;
    logic                sat_x;
    logic                sat_y;
    logic [OUT_BITS-1:0] val_x;
    logic [OUT_BITS-1:0] val_y;
    logic                r_out_v;
    logic [OUT_BITS-1:0] r_out_x;
    logic [OUT_BITS-1:0] r_out_y;
    t_status             r_out_st;

    // A quotient that needs more than OUT_BITS bits is caught up front.
    assign d_top = WW'(i_d_mag) << OUT_BITS;

    always_ff @(posedge i_clk) begin
        r_rem_x[0]  <= WW'(i_nx_mag);
        r_rem_y[0]  <= WW'(i_ny_mag);
        r_d[0]      <= i_d_mag;
        r_q_x[0]    <= '0;
        r_q_y[0]    <= '0;
        r_ovf_x[0]  <= (WW'(i_nx_mag) >= d_top);
        r_ovf_y[0]  <= (WW'(i_ny_mag) >= d_top);
        r_fl[0]     <= i_flags;
    end

    // One restoring step per stage, most significant quotient bit first.
    for (genvar s = 0; s < OUT_BITS; s++) begin : g_div
        localparam int SH = OUT_BITS - 1 - s;
        logic [WW-1:0] dsh;
        logic [WW:0]   dif_x;
        logic [WW:0]   dif_y;

        assign dsh   = WW'(r_d[s]) << SH;
        assign dif_x = {1'b0, r_rem_x[s]} - {1'b0, dsh};
        assign dif_y = {1'b0, r_rem_y[s]} - {1'b0, dsh};

        always_ff @(posedge i_clk) begin
            r_rem_x[s+1] <= dif_x[WW] ? r_rem_x[s] : dif_x[WW-1:0];
            r_rem_y[s+1] <= dif_y[WW] ? r_rem_y[s] : dif_y[WW-1:0];
            r_q_x[s+1]   <= {r_q_x[s][OUT_BITS-2:0], ~dif_x[WW]};
            r_q_y[s+1]   <= {r_q_y[s][OUT_BITS-2:0], ~dif_y[WW]};
            r_d[s+1]     <= r_d[s];
            r_ovf_x[s+1] <= r_ovf_x[s];
            r_ovf_y[s+1] <= r_ovf_y[s];
            r_fl[s+1]    <= r_fl[s];
        end
    end

    // A negative result may reach one step further than a positive one.
    assign sat_x = r_ovf_x[OUT_BITS] || (r_q_x[OUT_BITS][OUT_BITS-1] &&
                   (!r_fl[OUT_BITS].neg_x || (|r_q_x[OUT_BITS][OUT_BITS-2:0])));
    assign sat_y = r_ovf_y[OUT_BITS] || (r_q_y[OUT_BITS][OUT_BITS-1] &&
                   (!r_fl[OUT_BITS].neg_y || (|r_q_y[OUT_BITS][OUT_BITS-2:0])));

    always_comb begin
        if (sat_x) begin
            val_x = r_fl[OUT_BITS].neg_x ? {1'b1, {(OUT_BITS-1){1'b0}}}
                                         : {1'b0, {(OUT_BITS-1){1'b1}}};
        end else begin
            val_x = r_fl[OUT_BITS].neg_x ? -r_q_x[OUT_BITS] : r_q_x[OUT_BITS];
        end
        if (sat_y) begin
            val_y = r_fl[OUT_BITS].neg_y ? {1'b1, {(OUT_BITS-1){1'b0}}}
                                         : {1'b0, {(OUT_BITS-1){1'b1}}};
        end else begin
            val_y = r_fl[OUT_BITS].neg_y ? -r_q_y[OUT_BITS] : r_q_y[OUT_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_fl[OUT_BITS].zero) begin
            r_out_x  <= '0;
            r_out_y  <= '0;
            r_out_st <= ST_ZERO;
        end else begin
            r_out_x  <= val_x;
            r_out_y  <= val_y;
            r_out_st <= (sat_x || sat_y) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_v     <= {r_v[OUT_BITS-1:0], i_valid};
            r_out_v <= r_v[OUT_BITS];
        end
    end

    assign o_valid  = r_out_v;
    assign o_x      = r_out_x;
    assign o_y      = r_out_y;
    assign o_status = r_out_st;

endmodule

// ===== rtl/core/homography_point_map_unit.sv =====
// A point accepted by the input passes through the 3 product, sum and rounding
// stages, the operand queue, one overflow stage, 16 restoring division stages,
// the output register and the output queue before it shows on the output ports.
// Throughput: one point per cycle while full is low, set by the fully pipelined divider.
// Reset is synchronous and active low; it empties both queues, clears the
// pipeline valid bits and loads the identity matrix.
module homography_point_map_unit #(
    parameter int COORD_BITS = 11,
    parameter int FRAC_BITS  = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [COORD_BITS-1:0]        i_x_in,
    input  logic [COORD_BITS-1:0]        i_y_in,
    output logic                         empty,
    input  logic                         pop,
    output logic signed [hpm_pkg::OUT_BITS-1:0] o_x_out,
    output logic signed [hpm_pkg::OUT_BITS-1:0] o_y_out,
    output logic [1:0]                   o_status,
    input  logic                         i_cfg_we,
    input  logic [2:0]                   i_cfg_addr,
    input  logic [hpm_pkg::COEF_BITS-1:0] i_cfg_data
);
    import hpm_pkg::*;

    localparam int SW    = COEF_BITS + COORD_BITS + 3;
    localparam int NW    = SW + FRAC_BITS + 2;
    localparam int DW    = SW + 1;
    localparam int MID_W = 2 * NW + DW + FLAG_BITS;
    localparam int OUT_W = 2 * OUT_BITS + 2;
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    t_coef          r_coef [NUM_COEF];
    logic [CNT_W-1:0] r_count;
    logic           accept;
    logic           release_w;

    logic           fr_valid;
    logic [NW-1:0]  fr_nx, fr_ny;
    logic [DW-1:0]  fr_d;
    t_div_flags     fr_flags;

    logic [MID_W-1:0] mid_in, mid_out;
    logic           mid_empty, mid_full;
    logic [NW-1:0]  bk_nx, bk_ny;
    logic [DW-1:0]  bk_d;
    t_div_flags     bk_flags;

    logic           bk_valid;
    logic [OUT_BITS-1:0] bk_x, bk_y;
    t_status        bk_status;
    logic [OUT_W-1:0] out_in, out_data;
    logic           out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COEF; i++) begin
                r_coef[i] <= '0;
            end
            r_coef[REG_H00] <= ONE_Q16;
            r_coef[REG_H11] <= ONE_Q16;
        end else if (i_cfg_we) begin
            r_coef[t_reg_idx'(i_cfg_addr)] <= i_cfg_data;
        end
    end

    // Every accepted word holds a slot in the output queue until it is popped,
    // so the pipeline behind the input never has to stall.
    assign accept    = push && !full;
    assign release_w = pop && !empty;
    assign full      = (r_count == CNT_W'(OUT_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= r_count + CNT_W'(accept) - CNT_W'(release_w);
        end
    end

    hpm_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_x      (i_x_in),
        .i_y      (i_y_in),
        .i_coef   (r_coef),
        .o_valid  (fr_valid),
        .o_nx_mag (fr_nx),
        .o_ny_mag (fr_ny),
        .o_d_mag  (fr_d),
        .o_flags  (fr_flags)
    );

    assign mid_in = {fr_nx, fr_ny, fr_d, fr_flags};

    hpm_queue #(.WIDTH(MID_W), .DEPTH(MID_DEPTH)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_valid),
        .i_data  (mid_in),
        .i_pop   (!mid_empty),
        .o_data  (mid_out),
        .o_empty (mid_empty),
        .o_full  (mid_full)
    );

    assign {bk_nx, bk_ny, bk_d, bk_flags} = mid_out;

    hpm_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!mid_empty),
        .i_nx_mag (bk_nx),
        .i_ny_mag (bk_ny),
        .i_d_mag  (bk_d),
        .i_flags  (bk_flags),
        .o_valid  (bk_valid),
        .o_x      (bk_x),
        .o_y      (bk_y),
        .o_status (bk_status)
    );

    assign out_in = {bk_x, bk_y, bk_status};

    hpm_queue #(.WIDTH(OUT_W), .DEPTH(OUT_DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (bk_valid),
        .i_data  (out_in),
        .i_pop   (pop),
        .o_data  (out_data),
        .o_empty (empty),
        .o_full  (out_full)
    );

    assign o_x_out  = $signed(out_data[OUT_W-1 -: OUT_BITS]);
    assign o_y_out  = $signed(out_data[OUT_BITS+1 -: OUT_BITS]);
    assign o_status = out_data[1:0];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(OUT_DEPTH))
        else $error("word count exceeds output queue depth");

    a_mid_never_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !mid_full)
        else $error("operand queue filled up");

    a_out_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bk_valid |-> !out_full)
        else $error("result written into a full output queue");

    a_zero_outputs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == ST_ZERO) |-> (o_x_out == '0 && o_y_out == '0))
        else $error("zero denominator word carries a nonzero point");

endmodule
